// ===== rtl/core/icube_pkg.sv =====
// Shared types, codes and lookup tables of the indented cube triangulator.
// Depends on nothing; the core module refers to it by scoped names.
package icube_pkg;

   // Width of one output coordinate and of one input origin coordinate.
   localparam int unsigned COORD_W = 22;
   localparam int unsigned POS_W   = 21;

   // Triangle numbering: two per face, twelve per cube.
   localparam logic [3:0] LAST_TRI = 4'd11;

   // Kind codes of a leaf cube; the unused code behaves as empty.
   typedef enum logic [1:0] {
      KIND_EMPTY    = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_INDENTED = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [POS_W-1:0]   pos_type;

   // One vertex: x, y, z coordinates.
   typedef coord_type [2:0] vtx_type;

   // Indentation of one corner: x, y, z steps of three bits each.
   typedef logic [2:0][2:0] corner_ind_type;

   // Three corner numbers of one triangle, vertex a at index 0.
   typedef logic [2:0][2:0] tri_type;

   // Corners compared to pick one face's diagonal.
   typedef struct packed {
      logic [1:0] axis;
      logic [2:0] left0;
      logic [2:0] left1;
      logic [2:0] right0;
      logic [2:0] right1;
   } face_cmp_type;

   // Face diagonal test: faces x0, x1, y0, y1, z0, z1.
   function automatic face_cmp_type face_cmp(input logic [2:0] face);
      face_cmp_type fc;
      unique case (face)
         3'd0:    fc = '{axis: 2'd0, left0: 3'd0, left1: 3'd3, right0: 3'd1, right1: 3'd2};
         3'd1:    fc = '{axis: 2'd0, left0: 3'd4, left1: 3'd7, right0: 3'd5, right1: 3'd6};
         3'd2:    fc = '{axis: 2'd1, left0: 3'd0, left1: 3'd5, right0: 3'd1, right1: 3'd4};
         3'd3:    fc = '{axis: 2'd1, left0: 3'd2, left1: 3'd7, right0: 3'd3, right1: 3'd6};
         3'd4:    fc = '{axis: 2'd2, left0: 3'd0, left1: 3'd6, right0: 3'd2, right1: 3'd4};
         3'd5:    fc = '{axis: 2'd2, left0: 3'd1, left1: 3'd7, right0: 3'd3, right1: 3'd6};
         default: fc = '0;
      endcase
      return fc;
   endfunction

   // Corners of one triangle for either diagonal; sel is the face test result.
   function automatic tri_type tri_corners(input logic [3:0] idx, input logic sel);
      tri_type t;
      unique case (idx)
         4'd0:    t = sel ? {3'd2, 3'd1, 3'd0} : {3'd3, 3'd2, 3'd0};
         4'd1:    t = sel ? {3'd3, 3'd2, 3'd1} : {3'd3, 3'd1, 3'd0};
         4'd2:    t = sel ? {3'd6, 3'd5, 3'd4} : {3'd7, 3'd6, 3'd4};
         4'd3:    t = sel ? {3'd7, 3'd6, 3'd5} : {3'd7, 3'd5, 3'd4};
         4'd4:    t = sel ? {3'd4, 3'd1, 3'd0} : {3'd5, 3'd1, 3'd0};
         4'd5:    t = sel ? {3'd5, 3'd4, 3'd1} : {3'd4, 3'd5, 3'd1};
         4'd6:    t = sel ? {3'd6, 3'd3, 3'd2} : {3'd7, 3'd3, 3'd2};
         4'd7:    t = sel ? {3'd7, 3'd6, 3'd3} : {3'd6, 3'd7, 3'd2};
         4'd8:    t = sel ? {3'd4, 3'd2, 3'd0} : {3'd4, 3'd6, 3'd0};
         4'd9:    t = sel ? {3'd4, 3'd6, 3'd2} : {3'd6, 3'd2, 3'd0};
         4'd10:   t = sel ? {3'd5, 3'd3, 3'd1} : {3'd7, 3'd3, 3'd1};
         4'd11:   t = sel ? {3'd5, 3'd7, 3'd3} : {3'd5, 3'd7, 3'd1};
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/core/indented_cube_triangulator.sv =====
// An accepted cube beat passes the cube buffer, corner select, offset/base and output registers.
// The issue counter gives one triangle per cycle while the corner stage can take it, twelve per solid cube;
// an empty cube is taken and gives nothing.
// Pipeline: cube buffer, corner select, offset/base, vertex add; stalls hold every stage.
// Reset clears the valid bits and the triangle counter; payload registers are not reset.
// Depends on icube_pkg for types, codes and the face and triangle tables.
module indented_cube_triangulator #(
   parameter int unsigned ROOT_SHIFT = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cube_kind,
   input  logic [20:0] req_pos_x,
   input  logic [20:0] req_pos_y,
   input  logic [20:0] req_pos_z,
   input  logic [4:0]  req_level,
   input  logic [35:0] req_indent_low,
   input  logic [35:0] req_indent_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_tri_index,
   output logic [21:0] rsp_a_x,
   output logic [21:0] rsp_a_y,
   output logic [21:0] rsp_a_z,
   output logic [21:0] rsp_b_x,
   output logic [21:0] rsp_b_y,
   output logic [21:0] rsp_b_z,
   output logic [21:0] rsp_c_x,
   output logic [21:0] rsp_c_y,
   output logic [21:0] rsp_c_z,
   output logic        rsp_last
);

   // Deepest level that still has a whole unit per indentation step.
   localparam int unsigned LV_MAX = ROOT_SHIFT - 3;

   // Cube buffer.
   logic                                cube_valid_ff;
   icube_pkg::pos_type [2:0]            cube_pos_ff;
   icube_pkg::corner_ind_type [7:0]     cube_ind_ff;
   logic [5:0]                          cube_sel_ff;
   logic [4:0]                          cube_sh_ff;
   logic [3:0]                          cnt_ff;

   // Corner select stage.
   logic                                s1_valid_ff;
   logic [3:0]                          s1_idx_ff;
   icube_pkg::tri_type                  s1_corner_ff;
   icube_pkg::corner_ind_type [2:0]     s1_ind_ff;
   icube_pkg::pos_type [2:0]            s1_pos_ff;
   logic [4:0]                          s1_sh_ff;

   // Offset and base stage.
   logic                                s2_valid_ff;
   logic [3:0]                          s2_idx_ff;
   logic [2:0][2:0]                     s2_far_ff;
   icube_pkg::vtx_type [2:0]            s2_base_ff;
   icube_pkg::vtx_type [2:0]            s2_d_ff;
   logic [2:0][2:0]                     s2_far_in;
   icube_pkg::vtx_type [2:0]            s2_base_in;
   icube_pkg::vtx_type [2:0]            s2_d_in;

   // Output stage.
   logic                                rsp_valid_ff;
   logic [3:0]                          rsp_idx_ff;
   icube_pkg::vtx_type [2:0]            rsp_vtx_ff;
   icube_pkg::vtx_type [2:0]            rsp_vtx_in;

   // Load decode of an incoming cube.
   icube_pkg::corner_ind_type [7:0]     cube_ind_in;
   logic [5:0]                          cube_sel_in;
   logic [4:0]                          cube_sh_in;
   logic                                cube_keep_in;
   logic                                cube_load;

   // Stage enables.
   logic                                out_load;
   logic                                s2_load;
   logic                                s1_load;
   logic                                issue;
   logic                                issue_last;
   icube_pkg::tri_type                  issue_corner;
   icube_pkg::coord_type                s2_size;

   // A stage takes a beat when it is empty or its content moves on.
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign s2_load    = !s2_valid_ff || out_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign issue      = cube_valid_ff && s1_load;
   assign issue_last = issue && (cnt_ff == icube_pkg::LAST_TRI);

   // A new cube is taken once the last triangle of the current one issues.
   assign req_stall = cube_valid_ff && !issue_last;
   assign cube_load = req_valid && !req_stall;

   // Decode kind, indentations, face diagonals and step shift of the incoming cube.
   always_comb begin
      icube_pkg::face_cmp_type fc;
      logic [3:0]              left;
      logic [3:0]              right;
      logic [4:0]              lv;
      cube_ind_in  = {req_indent_high, req_indent_low};
      cube_keep_in = 1'b0;
      unique case (icube_pkg::kind_type'(req_cube_kind))
         icube_pkg::KIND_FULL: begin
            cube_ind_in  = '0;
            cube_keep_in = 1'b1;
         end
         icube_pkg::KIND_INDENTED: begin
            cube_keep_in = 1'b1;
         end
         default: begin
            cube_keep_in = 1'b0;
         end
      endcase
      for (int f = 0; f < 6; f++) begin
         fc    = icube_pkg::face_cmp(3'(f));
         left  = {1'b0, cube_ind_in[fc.left0][fc.axis]}
               + {1'b0, cube_ind_in[fc.left1][fc.axis]};
         right = {1'b0, cube_ind_in[fc.right0][fc.axis]}
               + {1'b0, cube_ind_in[fc.right1][fc.axis]};
         cube_sel_in[f] = (left >= right);
      end
      lv         = (req_level > 5'(LV_MAX)) ? 5'(LV_MAX) : req_level;
      cube_sh_in = 5'(LV_MAX) - lv;
   end

   // Corners of the triangle that issues now.
   assign issue_corner = icube_pkg::tri_corners(cnt_ff, cube_sel_ff[cnt_ff[3:1]]);

   // Cube buffer and triangle counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cube_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (cube_load) begin
            cube_valid_ff <= cube_keep_in;
         end else if (issue_last) begin
            cube_valid_ff <= 1'b0;
         end
         if (issue) begin
            cnt_ff <= issue_last ? 4'd0 : cnt_ff + 4'd1;
         end
      end
      if (cube_load) begin
         cube_pos_ff <= {req_pos_z, req_pos_y, req_pos_x};
         cube_ind_ff <= cube_ind_in;
         cube_sel_ff <= cube_sel_in;
         cube_sh_ff  <= cube_sh_in;
      end
   end

   // Corner select stage: triangle corners and their indentations.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= issue;
      end
      if (issue) begin
         s1_idx_ff    <= cnt_ff;
         s1_corner_ff <= issue_corner;
         for (int k = 0; k < 3; k++) begin
            s1_ind_ff[k] <= cube_ind_ff[issue_corner[k]];
         end
         s1_pos_ff <= cube_pos_ff;
         s1_sh_ff  <= cube_sh_ff;
      end
   end

   // Offset and base: indentation times step, origin plus edge on the far side.
   assign s2_size = icube_pkg::coord_type'(8) << s1_sh_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            s2_far_in[k][a]  = s1_corner_ff[k][2-a];
            s2_d_in[k][a]    = icube_pkg::coord_type'(s1_ind_ff[k][a]) << s1_sh_ff;
            s2_base_in[k][a] = icube_pkg::coord_type'(s1_pos_ff[a])
                             + (s2_far_in[k][a] ? s2_size : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_load && s1_valid_ff) begin
         s2_idx_ff  <= s1_idx_ff;
         s2_far_ff  <= s2_far_in;
         s2_base_ff <= s2_base_in;
         s2_d_ff    <= s2_d_in;
      end
   end

   // Vertex add: near corners move up by the offset, far corners move down.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int a = 0; a < 3; a++) begin
            rsp_vtx_in[k][a] = s2_far_ff[k][a] ? s2_base_ff[k][a] - s2_d_ff[k][a]
                                               : s2_base_ff[k][a] + s2_d_ff[k][a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (out_load && s2_valid_ff) begin
         rsp_idx_ff <= s2_idx_ff;
         rsp_vtx_ff <= rsp_vtx_in;
      end
   end

   // Result beat.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tri_index = rsp_idx_ff;
   assign rsp_a_x       = rsp_vtx_ff[0][0];
   assign rsp_a_y       = rsp_vtx_ff[0][1];
   assign rsp_a_z       = rsp_vtx_ff[0][2];
   assign rsp_b_x       = rsp_vtx_ff[1][0];
   assign rsp_b_y       = rsp_vtx_ff[1][1];
   assign rsp_b_z       = rsp_vtx_ff[1][2];
   assign rsp_c_x       = rsp_vtx_ff[2][0];
   assign rsp_c_y       = rsp_vtx_ff[2][1];
   assign rsp_c_z       = rsp_vtx_ff[2][2];
   assign rsp_last      = (rsp_idx_ff == icube_pkg::LAST_TRI);

   // The triangle counter never passes the last triangle of a cube.
   assert property (@(posedge clock) disable iff (reset)
      cube_valid_ff |-> (cnt_ff <= icube_pkg::LAST_TRI))
      else $error("triangle counter out of range");

   // With every stage full and the output stalled, the corner stage holds its triangle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s2_valid_ff && s1_valid_ff)
         |=> (s1_valid_ff && $stable(s1_idx_ff)))
      else $error("corner stage lost a triangle under stall");

   // A new cube is only taken when the buffer is free or its last triangle issues.
   assert property (@(posedge clock) disable iff (reset)
      (cube_load && cube_valid_ff) |-> issue_last)
      else $error("cube buffer overwritten before its last triangle");

   // A cube's first triangle follows the last triangle of the one before.
   assert property (@(posedge clock) disable iff (reset)
      (issue && (cnt_ff == 4'd0)) |-> (!s1_valid_ff || (s1_idx_ff == icube_pkg::LAST_TRI)
                                       || !s2_load))
      else $error("triangle issued out of order");

endmodule

// ===== verif/indented_cube_triangulator_test.sv =====
// Self-checking testbench of the indented cube triangulator: random and directed leaf cubes in,
// twelve triangles per solid cube checked beat by beat against an in-bench predictor.
// Depends on icube_pkg for the cube kind codes and on the indented_cube_triangulator RTL.
module indented_cube_triangulator_test;

   localparam int TREE_SHIFT = 21;
   localparam int DEEPEST    = TREE_SHIFT - 3;
   localparam int LIMIT      = 100000;
   localparam int PER_PHASE  = 53;
   localparam logic [20:0] POS_MAX = 21'h1FFFFF;

   // One cube beat as the sender holds it.
   typedef struct packed {
      icube_pkg::kind_type kind;
      logic [20:0]         pos_x;
      logic [20:0]         pos_y;
      logic [20:0]         pos_z;
      logic [4:0]          level;
      logic [35:0]         indent_low;
      logic [35:0]         indent_high;
   } cube_beat_type;

   // One triangle beat: v[vertex][axis], vertex a at index 0, axis x at index 0.
   typedef struct packed {
      logic [3:0]             index;
      logic [2:0][2:0][21:0]  v;
      logic                   last;
   } tri_beat_type;

   // Corners whose indentation sums decide one face's diagonal.
   typedef struct packed {
      logic [1:0] axis;
      logic [2:0] left0;
      logic [2:0] left1;
      logic [2:0] right0;
      logic [2:0] right1;
   } diag_test_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cube_beat_type sent_cube = '0;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_taken = 1'b0;

   wire        req_stall;
   wire        rsp_valid;
   wire [3:0]  rsp_tri_index;
   wire [21:0] rsp_a_x, rsp_a_y, rsp_a_z;
   wire [21:0] rsp_b_x, rsp_b_y, rsp_b_z;
   wire [21:0] rsp_c_x, rsp_c_y, rsp_c_z;
   wire        rsp_last;

   cube_beat_type pending_q[$];
   tri_beat_type  tri_expect_q[$];

   int send_idle_pct = 30;
   int stall_pct     = 49;
   int cubes_pushed  = 0;
   int cubes_taken   = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   indented_cube_triangulator #(
      .ROOT_SHIFT(TREE_SHIFT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cube_kind(sent_cube.kind),
      .req_pos_x(sent_cube.pos_x),
      .req_pos_y(sent_cube.pos_y),
      .req_pos_z(sent_cube.pos_z),
      .req_level(sent_cube.level),
      .req_indent_low(sent_cube.indent_low),
      .req_indent_high(sent_cube.indent_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tri_index(rsp_tri_index),
      .rsp_a_x(rsp_a_x),
      .rsp_a_y(rsp_a_y),
      .rsp_a_z(rsp_a_z),
      .rsp_b_x(rsp_b_x),
      .rsp_b_y(rsp_b_y),
      .rsp_b_z(rsp_b_z),
      .rsp_c_x(rsp_c_x),
      .rsp_c_y(rsp_c_y),
      .rsp_c_z(rsp_c_z),
      .rsp_last(rsp_last)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Corners compared for each face, in face order x0, x1, y0, y1, z0, z1.
   function automatic diag_test_type diag_test(input int face);
      case (face)
         0:       return '{axis: 2'd0, left0: 3'd0, left1: 3'd3, right0: 3'd1, right1: 3'd2};
         1:       return '{axis: 2'd0, left0: 3'd4, left1: 3'd7, right0: 3'd5, right1: 3'd6};
         2:       return '{axis: 2'd1, left0: 3'd0, left1: 3'd5, right0: 3'd1, right1: 3'd4};
         3:       return '{axis: 2'd1, left0: 3'd2, left1: 3'd7, right0: 3'd3, right1: 3'd6};
         4:       return '{axis: 2'd2, left0: 3'd0, left1: 3'd6, right0: 3'd2, right1: 3'd4};
         default: return '{axis: 2'd2, left0: 3'd1, left1: 3'd7, right0: 3'd3, right1: 3'd6};
      endcase
   endfunction

   // Corners of one triangle as {a, b, c}; sel is set when the face's left sum is at least its right sum.
   function automatic logic [8:0] triangle_corners(input int index, input logic sel);
      case (index)
         0:       return sel ? {3'd0, 3'd1, 3'd2} : {3'd0, 3'd2, 3'd3};
         1:       return sel ? {3'd1, 3'd2, 3'd3} : {3'd0, 3'd1, 3'd3};
         2:       return sel ? {3'd4, 3'd5, 3'd6} : {3'd4, 3'd6, 3'd7};
         3:       return sel ? {3'd5, 3'd6, 3'd7} : {3'd4, 3'd5, 3'd7};
         4:       return sel ? {3'd0, 3'd1, 3'd4} : {3'd0, 3'd1, 3'd5};
         5:       return sel ? {3'd1, 3'd4, 3'd5} : {3'd1, 3'd5, 3'd4};
         6:       return sel ? {3'd2, 3'd3, 3'd6} : {3'd2, 3'd3, 3'd7};
         7:       return sel ? {3'd3, 3'd6, 3'd7} : {3'd2, 3'd7, 3'd6};
         8:       return sel ? {3'd0, 3'd2, 3'd4} : {3'd0, 3'd6, 3'd4};
         9:       return sel ? {3'd2, 3'd6, 3'd4} : {3'd0, 3'd2, 3'd6};
         10:      return sel ? {3'd1, 3'd3, 3'd5} : {3'd1, 3'd3, 3'd7};
         default: return sel ? {3'd3, 3'd7, 3'd5} : {3'd1, 3'd7, 3'd5};
      endcase
   endfunction

   // Places one 3-bit indentation at corner c, axis a of the packed 72-bit corner set.
   function automatic logic [71:0] corner_ind(input int c, input int a, input logic [2:0] v);
      return 72'(v) << (9 * c + 3 * a);
   endfunction

   // Computes the twelve triangles of one cube and queues them; empty kinds give none.
   task automatic predict_triangles(input cube_beat_type cube);
      logic [71:0]           all_ind;
      logic [2:0][20:0]      pos;
      logic [7:0][2:0][2:0]  ind;
      logic [7:0][2:0][22:0] corner_pos;
      logic [4:0]            lvl;
      logic [31:0]           step, size, offset;
      logic [3:0]            left_sum, right_sum;
      logic [8:0]            corners;
      logic                  sel;
      diag_test_type         diag;
      tri_beat_type          tri_beat;
      logic [1:0]            ax;
      logic [2:0]            cn;
      if (cube.kind != icube_pkg::KIND_FULL && cube.kind != icube_pkg::KIND_INDENTED) return;
      all_ind = {cube.indent_high, cube.indent_low};
      pos = {cube.pos_z, cube.pos_y, cube.pos_x};
      // Levels deeper than the finest whole-unit step are clamped.
      lvl = (cube.level > DEEPEST) ? 5'(DEEPEST) : cube.level;
      step = 32'd1 << (DEEPEST - lvl);
      size = step << 3;
      // Move each corner inward; far-side corners count back from the opposite face.
      for (int c = 0; c < 8; c++) begin
         for (int a = 0; a < 3; a++) begin
            ind[c][a] = (cube.kind == icube_pkg::KIND_INDENTED) ?
                        all_ind[9 * c + 3 * a +: 3] : 3'd0;
            offset = step * ind[c][a];
            if (((c >> (2 - a)) & 1) != 0) begin
               corner_pos[c][a] = 23'(32'(pos[a]) + size - offset);
            end else begin
               corner_pos[c][a] = 23'(32'(pos[a]) + offset);
            end
         end
      end
      // Two triangles per face, with the diagonal that keeps the face convex.
      for (int f = 0; f < 6; f++) begin
         diag = diag_test(f);
         ax = diag.axis;
         left_sum = {1'b0, ind[diag.left0][ax]} + {1'b0, ind[diag.left1][ax]};
         right_sum = {1'b0, ind[diag.right0][ax]} + {1'b0, ind[diag.right1][ax]};
         sel = (left_sum >= right_sum);
         for (int t = 0; t < 2; t++) begin
            tri_beat.index = 4'(2 * f + t);
            corners = triangle_corners(2 * f + t, sel);
            for (int k = 0; k < 3; k++) begin
               cn = corners[8 - 3 * k -: 3];
               for (int a = 0; a < 3; a++) begin
                  tri_beat.v[k][a] = corner_pos[cn][a][21:0];
               end
            end
            tri_beat.last = (tri_beat.index == icube_pkg::LAST_TRI);
            tri_expect_q.push_back(tri_beat);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [21:0] want, input logic [21:0] got);
      if (want !== got) begin
         $error("triangle field %s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic push_cube(input icube_pkg::kind_type kind, input logic [20:0] x,
                            input logic [20:0] y, input logic [20:0] z,
                            input logic [4:0] lvl, input logic [71:0] ind);
      cube_beat_type cube;
      cube = '{kind: kind, pos_x: x, pos_y: y, pos_z: z, level: lvl,
               indent_low: ind[35:0], indent_high: ind[71:36]};
      pending_q.push_back(cube);
      cubes_pushed++;
   endtask

   // Holds off until every queued cube is taken and its triangles have arrived.
   task automatic wait_drained();
      while (cubes_taken != cubes_pushed || tri_expect_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Driver: a new cube beat goes out at the falling edge once the previous one was taken, unless the sender idles.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            sent_cube <= pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Monitor: records accepted cube beats and checks each accepted triangle beat.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_triangles(sent_cube);
            cubes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (tri_expect_q.size() == 0) begin
               $error("triangle beat %0d arrived with no cube pending", rsp_tri_index);
               mismatches++;
            end else begin
               tri_beat_type want;
               want = tri_expect_q.pop_front();
               check_field("tri_index", 22'(want.index), 22'(rsp_tri_index));
               check_field("a_x", want.v[0][0], rsp_a_x);
               check_field("a_y", want.v[0][1], rsp_a_y);
               check_field("a_z", want.v[0][2], rsp_a_z);
               check_field("b_x", want.v[1][0], rsp_b_x);
               check_field("b_y", want.v[1][1], rsp_b_y);
               check_field("b_z", want.v[1][2], rsp_b_z);
               check_field("c_x", want.v[2][0], rsp_c_x);
               check_field("c_y", want.v[2][1], rsp_c_y);
               check_field("c_z", want.v[2][2], rsp_c_z);
               check_field("last", 22'(want.last), 22'(rsp_last));
            end
         end
      end
   end

   // Stimulus: directed cubes, then three random phases with different idling.
   initial begin
      logic [71:0]         left_wins, right_wins, ind;
      logic [2:0][20:0]    p;
      logic [4:0]          lvl;
      icube_pkg::kind_type kind;
      int                  r;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Every face with its right-hand sum larger, so each takes the other diagonal.
      right_wins = corner_ind(1, 0, 7) | corner_ind(2, 0, 7) | corner_ind(5, 0, 7)
                 | corner_ind(6, 0, 7) | corner_ind(1, 1, 7) | corner_ind(4, 1, 7)
                 | corner_ind(3, 1, 7) | corner_ind(6, 1, 7) | corner_ind(2, 2, 7)
                 | corner_ind(4, 2, 7) | corner_ind(3, 2, 7) | corner_ind(6, 2, 7);
      // Every face with its left-hand sum strictly larger.
      left_wins = corner_ind(0, 0, 7) | corner_ind(3, 0, 7) | corner_ind(4, 0, 7)
                | corner_ind(7, 0, 7) | corner_ind(0, 1, 7) | corner_ind(5, 1, 7)
                | corner_ind(2, 1, 7) | corner_ind(7, 1, 7) | corner_ind(0, 2, 7)
                | corner_ind(6, 2, 7) | corner_ind(1, 2, 7) | corner_ind(7, 2, 7);

      // Empty and meaningless kinds give nothing.
      push_cube(icube_pkg::KIND_EMPTY, POS_MAX, 21'd0, POS_MAX, 5'd3, {72{1'b1}});
      push_cube(icube_pkg::KIND_UNUSED, 21'd0, POS_MAX, 21'd0, 5'd31, {72{1'b1}});
      // Full cubes ignore their indentations, at both level extremes and past the deepest.
      push_cube(icube_pkg::KIND_FULL, 21'd0, 21'd0, 21'd0, 5'd0, {72{1'b1}});
      push_cube(icube_pkg::KIND_FULL, POS_MAX, POS_MAX, POS_MAX, 5'd18,
                72'h5A5A5A5A5A5A5A5A5A);
      push_cube(icube_pkg::KIND_FULL, 21'h0AAAAA, 21'h155555, 21'h0F0F0F, 5'd31, 72'd0);
      // Indented cubes with no and with full indentation.
      push_cube(icube_pkg::KIND_INDENTED, 21'd0, 21'd0, 21'd0, 5'd0, 72'd0);
      push_cube(icube_pkg::KIND_INDENTED, POS_MAX, POS_MAX, POS_MAX, 5'd0, {72{1'b1}});
      push_cube(icube_pkg::KIND_INDENTED, POS_MAX, POS_MAX, POS_MAX, 5'd18, {72{1'b1}});
      push_cube(icube_pkg::KIND_INDENTED, 21'd0, 21'd0, 21'd0, 5'd18, 72'd0);
      // Levels too deep are clamped.
      push_cube(icube_pkg::KIND_INDENTED, 21'h123456, 21'h0ABCDE, 21'h1F0001, 5'd19,
                right_wins);
      push_cube(icube_pkg::KIND_INDENTED, 21'h000001, 21'h1FFFFE, 21'h100000, 5'd31,
                left_wins);
      // Both diagonals on every face, including the bottom and top faces.
      push_cube(icube_pkg::KIND_INDENTED, 21'h040000, 21'h080000, 21'h0C0000, 5'd3,
                right_wins);
      push_cube(icube_pkg::KIND_INDENTED, 21'h040000, 21'h080000, 21'h0C0000, 5'd3,
                left_wins);
      push_cube(icube_pkg::KIND_INDENTED, 21'h1F0000, 21'h001000, 21'h000010, 5'd7,
                right_wins | left_wins);
      // Alternating bit patterns across both indentation words.
      push_cube(icube_pkg::KIND_INDENTED, 21'h155555, 21'h0AAAAA, 21'h155555, 5'd5,
                72'h555555555AAAAAAAAA);
      push_cube(icube_pkg::KIND_INDENTED, 21'h0AAAAA, 21'h155555, 21'h0AAAAA, 5'd12,
                72'hAAAAAAAAA555555555);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
         stall_pct     = (phase == 0) ? 49 : (phase == 1) ? 30 : 0;
         for (int n = 0; n < PER_PHASE; n++) begin
            r = $urandom_range(99);
            kind = (r < 70) ? icube_pkg::KIND_INDENTED : (r < 85) ? icube_pkg::KIND_FULL :
                   (r < 95) ? icube_pkg::KIND_EMPTY : icube_pkg::KIND_UNUSED;
            lvl = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19)) :
                                             5'($urandom_range(18));
            for (int a = 0; a < 3; a++) begin
               r = $urandom_range(7);
               p[a] = (r == 0) ? 21'd0 : (r == 1) ? POS_MAX : 21'($urandom);
            end
            ind = 72'({$urandom, $urandom, $urandom});
            // Now and then push every indentation to an extreme.
            if ($urandom_range(7) == 0) begin
               for (int c = 0; c < 8; c++) begin
                  for (int a = 0; a < 3; a++) begin
                     ind[9 * c + 3 * a +: 3] = ($urandom_range(1) == 1) ? 3'd7 : 3'd0;
                  end
               end
            end
            push_cube(kind, p[0], p[1], p[2], lvl, ind);
         end
         // The sender stays quiet until the phase has fully drained.
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
